/* src/threshold_report_scheduler_assert.svh */
// Assertion helpers shared by the scheduler RTL.
// Both expect clk and rst_n in scope.
`ifndef THRESHOLD_REPORT_SCHEDULER_ASSERT_SVH
`define THRESHOLD_REPORT_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define TRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/trs_pkg.sv */
package trs_pkg;

    localparam int VALUE_W     = 32;
    localparam int PERIOD_W    = 32;
    localparam int ENABLES_W   = 5;
    localparam int ACTION_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // request kinds
    localparam logic [ACTION_W-1:0] ACT_VALUE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ON    = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_OFF   = 2'd3;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PERIOD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PERIOD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLES    = 3'd5;

    // attr_enables bits
    localparam int EN_PMIN_BIT = 0;
    localparam int EN_PMAX_BIT = 1;
    localparam int EN_GT_BIT   = 2;
    localparam int EN_LT_BIT   = 3;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RESET = 32'd1000;

    typedef struct packed {
        logic        [PERIOD_W-1:0]  min_period_ms;
        logic        [PERIOD_W-1:0]  max_period_ms;
        logic signed [VALUE_W-1:0]   upper_threshold;
        logic signed [VALUE_W-1:0]   lower_threshold;
        logic signed [VALUE_W-1:0]   step_size;
        logic        [ENABLES_W-1:0] attr_enables;
    } trs_cfg_t;

    typedef struct packed {
        logic                      notify;
        logic signed [VALUE_W-1:0] report_value;
        logic                      observing;
    } trs_result_t;

endpackage

/* src/threshold_report_scheduler.sv */
// An accepted request is held in the input register until the result register can take it.
// Throughput: one request per cycle while the output does not stall; each request updates the
// scheduler state in a single pass between the input register and the result register.
// A full result register with out_ready low stalls the input register, then in_ready.
// Reset (rst_n low, asynchronous) clears the engine state and pipeline valids and loads the
// register defaults: min period 1000, all other registers zero.
module threshold_report_scheduler
    import trs_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [VALUE_W-1:0] sample,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      notify,
    output logic signed [VALUE_W-1:0] report_value,
    output logic                      observing
);

    `include "threshold_report_scheduler_assert.svh"

    trs_cfg_t    cfg;
    trs_result_t result;

    logic                      s1_valid_reg, s1_valid_next;
    logic [ACTION_W-1:0]       s1_action_reg;
    logic signed [VALUE_W-1:0] s1_sample_reg;
    logic                      out_valid_reg, out_valid_next;
    trs_result_t               out_reg;

    logic in_accept;
    logic out_load;

    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || out_load;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    trs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trs_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (out_load),
        .action (s1_action_reg),
        .sample (s1_sample_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_action_reg <= action;
            s1_sample_reg <= sample;
        end
        if (out_load)
            out_reg <= result;
    end

    assign out_valid    = out_valid_reg;
    assign notify       = out_reg.notify;
    assign report_value = out_reg.report_value;
    assign observing    = out_reg.observing;

    `TRS_ASSERT_NOW(a_notify_observing, out_valid_reg && out_reg.notify, out_reg.observing,
                    "report while not observing")
    `TRS_ASSERT_NOW(a_stall_holds_request, !in_ready, s1_valid_reg,
                    "input stalled with empty stage")
    `TRS_ASSERT_NOW(a_result_from_request, $rose(out_valid_reg), $past(s1_valid_reg),
                    "result without request")

endmodule

/* src/trs_cfg.sv */
module trs_cfg
    import trs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output trs_cfg_t               cfg
);

    localparam trs_cfg_t CFG_RESET = '{min_period_ms: MIN_PERIOD_RESET, default: '0};

    trs_cfg_t cfg_reg;
    trs_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_PERIOD: cfg_next.min_period_ms   = cfg_data[PERIOD_W-1:0];
                REG_MAX_PERIOD: cfg_next.max_period_ms   = cfg_data[PERIOD_W-1:0];
                REG_UPPER:      cfg_next.upper_threshold = cfg_data[VALUE_W-1:0];
                REG_LOWER:      cfg_next.lower_threshold = cfg_data[VALUE_W-1:0];
                REG_STEP:       cfg_next.step_size       = cfg_data[VALUE_W-1:0];
                REG_ENABLES:    cfg_next.attr_enables    = cfg_data[ENABLES_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/trs_engine.sv */
module trs_engine
    import trs_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [ACTION_W-1:0]       action,
    input  logic signed [VALUE_W-1:0] sample,
    input  trs_cfg_t                  cfg,
    output trs_result_t               result
);

    `include "threshold_report_scheduler_assert.svh"

    localparam int LOAD_W = (COUNT_WIDTH > PERIOD_W) ? COUNT_WIDTH : PERIOD_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

    logic signed [VALUE_W-1:0] cur_reg, cur_next;
    logic signed [VALUE_W-1:0] last_reg, last_next;
    logic signed [VALUE_W-1:0] band_high_reg, band_high_next;
    logic signed [VALUE_W-1:0] band_low_reg, band_low_next;
    logic                      active_reg, active_next;
    logic                      min_elapsed_reg, min_elapsed_next;
    logic                      max_elapsed_reg, max_elapsed_next;
    logic                      pending_reg, pending_next;
    logic                      out_of_range_reg, out_of_range_next;
    logic [COUNT_WIDTH-1:0]    min_count_reg, min_count_next;
    logic                      min_running_reg, min_running_next;
    logic [COUNT_WIDTH-1:0]    max_count_reg, max_count_next;
    logic                      max_running_reg, max_running_next;

    logic do_report;
    logic do_start;
    logic min_hit;
    logic max_hit;
    logic sent;

    function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [PERIOD_W-1:0] p);
        logic [LOAD_W-1:0] pw;
        logic [LOAD_W-1:0] cmax;
        pw   = LOAD_W'(p);
        cmax = LOAD_W'({COUNT_WIDTH{1'b1}});
        return (pw > cmax) ? COUNT_WIDTH'(cmax) : COUNT_WIDTH'(pw);
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_sum(input logic signed [VALUE_W:0] s);
        if (s[VALUE_W] != s[VALUE_W-1])
            return s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
        return s[VALUE_W-1:0];
    endfunction

    function automatic logic passes(input logic signed [VALUE_W-1:0] v,
                                    input logic signed [VALUE_W-1:0] bh,
                                    input logic signed [VALUE_W-1:0] bl,
                                    input trs_cfg_t c);
        logic gt;
        logic lt;
        gt = c.attr_enables[EN_GT_BIT];
        lt = c.attr_enables[EN_LT_BIT];
        if (!(v >= bh || v <= bl))
            return 1'b0;
        if (gt && lt)
            return (v > c.upper_threshold) || (v < c.lower_threshold);
        if (lt)
            return v < c.lower_threshold;
        if (gt)
            return v > c.upper_threshold;
        return 1'b1;
    endfunction

    always_comb
    begin
        cur_next          = cur_reg;
        last_next         = last_reg;
        band_high_next    = band_high_reg;
        band_low_next     = band_low_reg;
        active_next       = active_reg;
        min_elapsed_next  = min_elapsed_reg;
        max_elapsed_next  = max_elapsed_reg;
        pending_next      = pending_reg;
        out_of_range_next = out_of_range_reg;
        min_count_next    = min_count_reg;
        min_running_next  = min_running_reg;
        max_count_next    = max_count_reg;
        max_running_next  = max_running_reg;
        do_report         = 1'b0;
        do_start          = 1'b0;
        min_hit           = 1'b0;
        max_hit           = 1'b0;
        sent              = 1'b0;

        case (action)
            ACT_VALUE:
            begin
                cur_next = sample;
                if (sample != last_reg && active_reg)
                begin
                    last_next = sample;
                    if (passes(sample, band_high_reg, band_low_reg, cfg))
                    begin
                        if (min_elapsed_reg)
                        begin
                            min_elapsed_next = 1'b0;
                            max_elapsed_next = 1'b0;
                            min_running_next = 1'b0;
                            max_running_next = 1'b0;
                            do_report        = 1'b1;
                        end
                        else if (out_of_range_reg)
                        begin
                            pending_next = 1'b1;
                            do_start     = 1'b1;
                        end
                        else
                        begin
                            pending_next = 1'b1;
                        end
                    end
                    else if (cfg.attr_enables[EN_GT_BIT] || cfg.attr_enables[EN_LT_BIT])
                    begin
                        out_of_range_next = 1'b1;
                        min_elapsed_next  = 1'b0;
                        max_elapsed_next  = 1'b0;
                        min_running_next  = 1'b0;
                        max_running_next  = 1'b0;
                    end
                end
            end
            ACT_TICK:
            begin
                if (max_running_reg)
                begin
                    if (max_count_reg != '0)
                        max_count_next = max_count_reg - COUNT_ONE;
                    if (max_count_reg <= COUNT_ONE)
                    begin
                        max_hit          = 1'b1;
                        max_running_next = 1'b0;
                    end
                end
                if (min_running_reg)
                begin
                    if (min_count_reg != '0)
                        min_count_next = min_count_reg - COUNT_ONE;
                    if (min_count_reg <= COUNT_ONE)
                    begin
                        min_hit          = 1'b1;
                        min_running_next = 1'b0;
                    end
                end
                // min expiry goes first; a report from it drops the max expiry
                if (min_hit)
                begin
                    if (pending_reg || (cfg.attr_enables[EN_PMAX_BIT:EN_PMIN_BIT] == 2'b01))
                    begin
                        pending_next     = 1'b0;
                        max_running_next = 1'b0;
                        max_hit          = 1'b0;
                        do_report        = 1'b1;
                    end
                    else
                    begin
                        min_elapsed_next = 1'b1;
                    end
                end
                if (max_hit)
                begin
                    max_elapsed_next = 1'b1;
                    if (min_elapsed_next)
                        do_report = 1'b1;
                end
            end
            ACT_ON, ACT_OFF:
            begin
                active_next      = (action == ACT_ON);
                pending_next     = 1'b0;
                min_elapsed_next = 1'b0;
                max_elapsed_next = 1'b0;
                min_running_next = 1'b0;
                max_running_next = 1'b0;
                if (action == ACT_ON)
                begin
                    if (passes(cur_reg, band_high_reg, band_low_reg, cfg))
                        do_start = 1'b1;
                    else
                        out_of_range_next = 1'b1;
                end
                else
                begin
                    last_next = '0;
                end
            end
            default:
            begin
                cur_next = cur_reg;
            end
        endcase

        // report while observing: re-center the step band on the current value
        if (do_report && active_next)
        begin
            min_elapsed_next  = 1'b0;
            max_elapsed_next  = 1'b0;
            out_of_range_next = 1'b0;
            band_high_next    = sat_sum((VALUE_W+1)'(cur_next) + (VALUE_W+1)'(cfg.step_size));
            band_low_next     = sat_sum((VALUE_W+1)'(cur_next) - (VALUE_W+1)'(cfg.step_size));
            sent              = 1'b1;
        end

        if ((do_report || do_start) && cfg.attr_enables != '0)
        begin
            if (cfg.min_period_ms != '0)
            begin
                min_count_next   = load_count(cfg.min_period_ms);
                min_running_next = 1'b1;
            end
            else
            begin
                min_elapsed_next = 1'b1;
            end
            if (cfg.max_period_ms != '0)
            begin
                max_count_next   = load_count(cfg.max_period_ms);
                max_running_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg          <= '0;
            last_reg         <= '0;
            band_high_reg    <= '0;
            band_low_reg     <= '0;
            active_reg       <= 1'b0;
            min_elapsed_reg  <= 1'b0;
            max_elapsed_reg  <= 1'b0;
            pending_reg      <= 1'b0;
            out_of_range_reg <= 1'b0;
            min_count_reg    <= '0;
            min_running_reg  <= 1'b0;
            max_count_reg    <= '0;
            max_running_reg  <= 1'b0;
        end
        else if (step)
        begin
            cur_reg          <= cur_next;
            last_reg         <= last_next;
            band_high_reg    <= band_high_next;
            band_low_reg     <= band_low_next;
            active_reg       <= active_next;
            min_elapsed_reg  <= min_elapsed_next;
            max_elapsed_reg  <= max_elapsed_next;
            pending_reg      <= pending_next;
            out_of_range_reg <= out_of_range_next;
            min_count_reg    <= min_count_next;
            min_running_reg  <= min_running_next;
            max_count_reg    <= max_count_next;
            max_running_reg  <= max_running_next;
        end
    end

    assign result.notify       = sent;
    assign result.report_value = cur_next;
    assign result.observing    = active_next;

    `TRS_ASSERT_NOW(a_pending_needs_active, pending_reg, active_reg, "pending while not observing")
    `TRS_ASSERT_NOW(a_min_count_live, min_running_reg, min_count_reg != '0, "min countdown ran dry")
    `TRS_ASSERT_NEXT(a_report_restarts_min, step && sent && cfg.min_period_ms != '0 && cfg.attr_enables != '0, min_running_reg, "report did not restart min countdown")

endmodule

/* bench/tb_threshold_report_scheduler.sv */
`timescale 1ns / 100ps

module tb_threshold_report_scheduler;
    import trs_pkg::*;

    localparam int     CLK_HALF     = 4;
    localparam int     RESET_CYCLES = 12;
    localparam int     RANDOM_ITEMS = 1550;
    localparam longint CYCLE_LIMIT  = 400000;
    localparam longint Q_MAX        = 64'sd2147483647;
    localparam longint Q_MIN        = -64'sd2147483648;
    localparam logic [VALUE_W-1:0] Q_ONE     = 32'h0001_0000;
    localparam logic [VALUE_W-1:0] Q_TOP     = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] Q_BOTTOM  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] Q_HALF    = 32'h0000_8000;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [VALUE_W-1:0] sample;
    } sched_req_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [ACTION_W-1:0]       action = ACT_VALUE;
    logic signed [VALUE_W-1:0] sample = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      notify;
    logic signed [VALUE_W-1:0] report_value;
    logic                      observing;

    threshold_report_scheduler u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .notify       (notify),
        .report_value (report_value),
        .observing    (observing)
    );

    always #(CLK_HALF) clk = ~clk;

    longint cycle_count = 0;
    int     fail_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Scheduler prediction
    // ---------------------------------------------------------------
    trs_cfg_t model_cfg;

    longint cur_q = 0;
    longint prev_q = 0;
    longint band_hi = 0;
    longint band_lo = 0;
    bit     watching = 1'b0;
    bit     pmin_done = 1'b0;
    bit     pmax_done = 1'b0;
    bit     report_due = 1'b0;
    bit     outside_window = 1'b0;
    bit     pmin_run = 1'b0;
    bit     pmax_run = 1'b0;
    bit     sent_now = 1'b0;
    logic [PERIOD_W-1:0] pmin_left = '0;
    logic [PERIOD_W-1:0] pmax_left = '0;

    function automatic longint q_of(logic [VALUE_W-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    function automatic void halt_timers();
        pmin_done = 1'b0;
        pmax_done = 1'b0;
        pmin_run  = 1'b0;
        pmax_run  = 1'b0;
    endfunction

    // period and counter are both 32 bits wide, so a load never clamps
    function automatic void arm_timers();
        if (model_cfg.attr_enables == '0)
            return;
        if (model_cfg.min_period_ms != '0)
        begin
            pmin_left = model_cfg.min_period_ms;
            pmin_run  = 1'b1;
        end
        else
            pmin_done = 1'b1;
        if (model_cfg.max_period_ms != '0)
        begin
            pmax_left = model_cfg.max_period_ms;
            pmax_run  = 1'b1;
        end
    endfunction

    function automatic bit window_ok();
        bit gt_on;
        bit lt_on;
        gt_on = model_cfg.attr_enables[EN_GT_BIT];
        lt_on = model_cfg.attr_enables[EN_LT_BIT];
        if (!(cur_q >= band_hi || cur_q <= band_lo))
            return 1'b0;
        if (gt_on && lt_on)
            return cur_q > q_of(model_cfg.upper_threshold) ||
                   cur_q < q_of(model_cfg.lower_threshold);
        if (lt_on)
            return cur_q < q_of(model_cfg.lower_threshold);
        if (gt_on)
            return cur_q > q_of(model_cfg.upper_threshold);
        return 1'b1;
    endfunction

    function automatic void emit_report();
        if (watching)
        begin
            pmin_done      = 1'b0;
            pmax_done      = 1'b0;
            outside_window = 1'b0;
            band_hi        = clamp_q(cur_q + q_of(model_cfg.step_size));
            band_lo        = clamp_q(cur_q - q_of(model_cfg.step_size));
            sent_now       = 1'b1;
        end
        arm_timers();
    endfunction

    function automatic void take_sample(longint v);
        cur_q = v;
        if (cur_q == prev_q || !watching)
            return;
        prev_q = cur_q;
        if (window_ok())
        begin
            if (pmin_done)
            begin
                halt_timers();
                emit_report();
            end
            else if (outside_window)
            begin
                report_due = 1'b1;
                arm_timers();
            end
            else
                report_due = 1'b1;
        end
        else if (model_cfg.attr_enables[EN_GT_BIT] || model_cfg.attr_enables[EN_LT_BIT])
        begin
            outside_window = 1'b1;
            halt_timers();
        end
    endfunction

    function automatic void take_tick();
        bit min_hit;
        bit max_hit;
        min_hit = 1'b0;
        max_hit = 1'b0;
        if (pmax_run)
        begin
            if (pmax_left != '0)
                pmax_left = pmax_left - 1'b1;
            if (pmax_left == '0)
            begin
                max_hit  = 1'b1;
                pmax_run = 1'b0;
            end
        end
        if (pmin_run)
        begin
            if (pmin_left != '0)
                pmin_left = pmin_left - 1'b1;
            if (pmin_left == '0)
            begin
                min_hit  = 1'b1;
                pmin_run = 1'b0;
            end
        end
        // min expiry first; a report from it restarts the max countdown
        if (min_hit)
        begin
            if (report_due || (model_cfg.attr_enables[EN_PMIN_BIT] &&
                               !model_cfg.attr_enables[EN_PMAX_BIT]))
            begin
                report_due = 1'b0;
                pmax_run   = 1'b0;
                max_hit    = 1'b0;
                emit_report();
            end
            else
                pmin_done = 1'b1;
        end
        if (max_hit)
        begin
            pmax_done = 1'b1;
            if (pmin_done)
                emit_report();
        end
    endfunction

    function automatic void set_observe(bit on);
        watching   = on;
        report_due = 1'b0;
        halt_timers();
        if (on)
        begin
            if (window_ok())
                arm_timers();
            else
                outside_window = 1'b1;
        end
        else
            prev_q = 0;
    endfunction

    function automatic trs_result_t next_report(sched_req_t r);
        trs_result_t res;
        sent_now = 1'b0;
        case (r.action)
            ACT_VALUE: take_sample(q_of(r.sample));
            ACT_TICK:  take_tick();
            ACT_ON:    set_observe(1'b1);
            default:   set_observe(1'b0);
        endcase
        res.notify       = sent_now;
        res.report_value = cur_q[VALUE_W-1:0];
        res.observing    = watching;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Request driver
    // ---------------------------------------------------------------
    sched_req_t  req_q[$];
    trs_result_t report_q[$];
    sched_req_t  held_req;
    int          burst_left = 1;
    int          gap_left = 0;

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            report_q.push_back(next_report(held_req));
        if (!in_valid || in_ready)
        begin
            if (rst_n && gap_left == 0 && req_q.size() != 0)
            begin
                held_req = req_q.pop_front();
                in_valid <= 1'b1;
                action   <= held_req.action;
                sample   <= held_req.sample;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 7))
                        0, 1, 2: gap_left = 0;
                        3, 4:    gap_left = $urandom_range(1, 3);
                        5, 6:    gap_left = $urandom_range(4, 10);
                        default: gap_left = $urandom_range(15, 30);
                    endcase
                end
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and receiver stalls
    // ---------------------------------------------------------------
    trs_result_t oldest_report;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          stall_tick = 0;

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (report_q.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                oldest_report = report_q.pop_front();
                if (notify !== oldest_report.notify)
                begin
                    $error("notify: expected %0d actual %0d", oldest_report.notify, notify);
                    fail_count++;
                end
                if (report_value !== oldest_report.report_value)
                begin
                    $error("report_value: expected %0d actual %0d",
                           oldest_report.report_value, report_value);
                    fail_count++;
                end
                if (observing !== oldest_report.observing)
                begin
                    $error("observing: expected %0d actual %0d",
                           oldest_report.observing, observing);
                    fail_count++;
                end
            end
        end

        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 300);
        end
        else
            stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= $urandom_range(0, 1);
            2:       out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((stall_tick % 7) < 3);
        endcase
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    logic [VALUE_W-1:0] last_pushed = '0;

    function automatic void push_req(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val);
        sched_req_t r;
        r.action = act;
        r.sample = val;
        req_q.push_back(r);
        if (act == ACT_VALUE)
            last_pushed = val;
    endfunction

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_MIN_PERIOD: model_cfg.min_period_ms   = data;
            REG_MAX_PERIOD: model_cfg.max_period_ms   = data;
            REG_UPPER:      model_cfg.upper_threshold = data;
            REG_LOWER:      model_cfg.lower_threshold = data;
            REG_STEP:       model_cfg.step_size       = data;
            default:        model_cfg.attr_enables    = data[ENABLES_W-1:0];
        endcase
    endtask

    task automatic load_settings(logic [31:0] pmin, logic [31:0] pmax, logic [31:0] upper,
                                 logic [31:0] lower, logic [31:0] step, logic [4:0] en);
        write_reg(REG_MIN_PERIOD, pmin);
        write_reg(REG_MAX_PERIOD, pmax);
        write_reg(REG_UPPER, upper);
        write_reg(REG_LOWER, lower);
        write_reg(REG_STEP, step);
        write_reg(REG_ENABLES, {27'd0, en});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (req_q.size() != 0 || in_valid || report_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_period(int span);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(1, 200);
            default: return $urandom_range(1, span);
        endcase
    endfunction

    // levels and samples mostly on a half-unit grid so equalities happen
    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return Q_TOP;
            1:       return Q_BOTTOM;
            2:       return $urandom();
            default: return ($urandom_range(0, 16) - 8) * Q_HALF;
        endcase
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q_TOP;
            2:       return Q_BOTTOM;
            3:       return -($urandom_range(1, 4) * Q_HALF);
            default: return $urandom_range(0, 4) * Q_HALF;
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: return ($urandom_range(0, 32) - 16) * Q_HALF;
            9, 10, 11:                 return last_pushed;
            12:                        return model_cfg.upper_threshold;
            13:                        return model_cfg.lower_threshold;
            14, 15, 16:                return $urandom();
            17:                        return Q_TOP;
            18:                        return Q_BOTTOM;
            default:                   return $urandom_range(0, 32'h80000) - 32'h40000;
        endcase
    endfunction

    initial
    begin
        int random_items;
        int phase_items;
        int pick;

        model_cfg = '0;
        model_cfg.min_period_ms = MIN_PERIOD_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no attributes, so countdowns never start
        push_req(ACT_VALUE, 32'h0005_0000);
        push_req(ACT_ON, $urandom());
        push_req(ACT_VALUE, Q_TOP);
        push_req(ACT_VALUE, Q_BOTTOM);
        push_req(ACT_TICK, $urandom());
        push_req(ACT_VALUE, Q_BOTTOM);
        push_req(ACT_OFF, $urandom());
        wait_idle();

        // equal periods: both expiries on one tick, with and without a pending report;
        // a full-scale step saturates the band
        load_settings(32'd3, 32'd3, Q_ONE, -Q_ONE, Q_TOP, 5'h1F);
        push_req(ACT_ON, $urandom());
        push_req(ACT_VALUE, Q_TOP);
        repeat (6) push_req(ACT_TICK, $urandom());
        push_req(ACT_VALUE, '0);
        push_req(ACT_VALUE, 32'hFFFF_FFFF);
        push_req(ACT_OFF, $urandom());
        wait_idle();

        // zero min period, longest max period, most negative step
        load_settings(32'd0, 32'hFFFF_FFFF, '0, '0, Q_BOTTOM, 5'h01);
        push_req(ACT_ON, $urandom());
        push_req(ACT_VALUE, 32'hFFFF_FFFF);
        push_req(ACT_TICK, $urandom());
        push_req(ACT_VALUE, 32'h0003_0000);
        push_req(ACT_TICK, $urandom());
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            load_settings(pick_period(12), pick_period(20), pick_level(), pick_level(),
                          pick_step(), $urandom_range(0, 31));
            phase_items = $urandom_range(60, 180);
            if ($urandom_range(0, 4) != 0)
                push_req(ACT_ON, $urandom());
            repeat (phase_items)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 42)
                    push_req(ACT_TICK, $urandom());
                else if (pick < 92)
                    push_req(ACT_VALUE, pick_sample());
                else if (pick < 96)
                    push_req(ACT_ON, $urandom());
                else
                    push_req(ACT_OFF, $urandom());
            end
            random_items += phase_items;
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/trs_pkg.sv
src/trs_cfg.sv
src/trs_engine.sv
src/threshold_report_scheduler.sv
bench/tb_threshold_report_scheduler.sv
